// ----- hdl/dtq_pkg.sv -----
// Shared types and constants for the deadline timer queue.
// Used by dtq_store, dtq_div and deadline_timer_queue; no dependencies.
package dtq_pkg;

  // Field widths
  localparam int DEADLINE_W = 49;
  localparam int NOW_W      = 48;
  localparam int DELAY_W    = 41;
  localparam int TASK_W     = 16;
  localparam int WAIT_W     = 31;
  localparam int KIND_W     = 3;

  // Operation codes (input tuser)
  localparam logic OP_SCHEDULE = 1'b0;
  localparam logic OP_SERVICE  = 1'b1;

  // Result kinds (output tuser)
  localparam logic [KIND_W-1:0] KIND_ACCEPTED = 3'd0;
  localparam logic [KIND_W-1:0] KIND_NEGATIVE = 3'd1;
  localparam logic [KIND_W-1:0] KIND_FULL     = 3'd2;
  localparam logic [KIND_W-1:0] KIND_DUE      = 3'd3;
  localparam logic [KIND_W-1:0] KIND_WAIT     = 3'd4;
  localparam logic [KIND_W-1:0] KIND_EMPTY    = 3'd5;

  // Divide by 1000: (span >> 3) / 125 by a rounded-up reciprocal, 2^45 scale
  localparam int                    US_PER_MS   = 1000;
  localparam int                    RECIP_W     = 39;
  localparam logic [RECIP_W-1:0]    RECIP_125   = 39'd281474976711;   // ceil(2^45 / 125)
  localparam int                    RECIP_SHIFT = 45;
  localparam logic [WAIT_W-1:0]     WAIT_MAX    = 31'd1099511627;
  localparam logic [DEADLINE_W-1:0] SAT_SPAN    = 49'd1099511628000;  // 1000 * (WAIT_MAX + 1)

  // One queue entry
  typedef struct packed {
    logic [DEADLINE_W-1:0] deadline;
    logic [TASK_W-1:0]     task_id;
  } entry_t;

  // Sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_INS_STEP,
    ST_INS_CMP,
    ST_INS_DONE,
    ST_SRV_READ,
    ST_SRV_CMP,
    ST_SRV_DIV
  } state_t;

endpackage

// ----- hdl/deadline_timer_queue.sv -----
// Deadline timer queue top level: sequencer, output register, assertions.
// Depends on dtq_pkg, dtq_store and dtq_div.
//
// Usage:
//   Input items arrive on s_axis_*. tuser is the operation: 0 schedules
//   task_id to wake at now_us + delay_us, 1 services the queue at now_us.
//   Results leave on m_axis_*, tuser giving the result kind and tlast set on
//   the final result of each input item. A schedule item gives one result;
//   a service item gives one due result per expired task, earliest first
//   (equal deadlines in arrival order), then a wait or empty result.
// Timing:
//   The queue is a circular buffer in one memory with a registered read. A
//   schedule item walks the queued entries with a later deadline, one
//   read/write per cycle, then writes the new entry; an ignored or dropped
//   item answers at once. A service item pops each due task in turn, then
//   runs the pipelined divide by 1000, or ends empty if the queue empties.
//   One item is in work at a time; s_axis_tready is low while it runs.
// Reset and stall:
//   rst clears the sequencer, fill count, head pointer and output valid; the
//   memory is not cleared. A stall on m_axis_tready holds result and result loads.
module deadline_timer_queue #(
  parameter int QUEUE_DEPTH = 16
) (
  input  logic         clk,
  input  logic         rst,
  input  logic         s_axis_tvalid,
  output logic         s_axis_tready,
  // [15:0] task_id, [56:16] delay_us, [104:57] now_us, [111:105] zero
  input  logic [111:0] s_axis_tdata,
  // [0] operation
  input  logic         s_axis_tuser,
  output logic         m_axis_tvalid,
  input  logic         m_axis_tready,
  // [15:0] woken_task, [46:16] wait_ms, [47] zero
  output logic [47:0]  m_axis_tdata,
  // [2:0] result_kind
  output logic [2:0]   m_axis_tuser,
  output logic         m_axis_tlast
);
  import dtq_pkg::*;

  localparam int AW = $clog2(QUEUE_DEPTH);
  localparam int CW = $clog2(QUEUE_DEPTH + 1);
  localparam int SW = AW + 1;

  // Logical queue position to memory address
  function automatic logic [AW-1:0] to_phys(input logic [AW-1:0] hd,
                                            input logic [CW-1:0] lg);
    logic [SW-1:0] s;
    s = SW'(hd) + SW'(lg);
    if (s >= SW'(QUEUE_DEPTH)) begin
      s = s - SW'(QUEUE_DEPTH);
    end
    return s[AW-1:0];
  endfunction

  state_t state, state_next;

  logic [AW-1:0]         head, head_next;
  logic [CW-1:0]         count, count_next;
  logic [CW-1:0]         pos, pos_next;
  logic [DEADLINE_W-1:0] dl;
  logic [TASK_W-1:0]     task_r;
  logic [NOW_W-1:0]      now_r;

  logic [KIND_W-1:0]     kind_r;
  logic [TASK_W-1:0]     woken_r;
  logic [WAIT_W-1:0]     wait_r;
  logic                  last_r;
  logic                  out_valid;

  logic                  accept;
  logic                  out_free;
  logic                  in_op;
  logic [TASK_W-1:0]     in_task;
  logic signed [DELAY_W-1:0] in_delay;
  logic [NOW_W-1:0]      in_now;
  logic                  in_neg;
  logic                  q_full;
  logic                  rd_later;
  logic                  rd_due;

  logic                  mem_we, mem_re;
  logic [AW-1:0]         mem_waddr, mem_raddr;
  entry_t                mem_wdata, rd_entry;

  logic                  div_start, div_done;
  logic [WAIT_W-1:0]     div_q;

  logic                  out_load;
  logic [KIND_W-1:0]     out_kind;
  logic [TASK_W-1:0]     out_task;
  logic [WAIT_W-1:0]     out_wait;
  logic                  out_last;
  logic                  load_item;

  // Input unpacking
  assign in_op    = s_axis_tuser;
  assign in_task  = s_axis_tdata[15:0];
  assign in_delay = s_axis_tdata[56:16];
  assign in_now   = s_axis_tdata[104:57];
  assign in_neg   = in_delay[DELAY_W-1];
  assign q_full   = (count == CW'(QUEUE_DEPTH));

  assign out_free      = !out_valid || m_axis_tready;
  assign s_axis_tready = (state == ST_IDLE) && out_free;
  assign accept        = s_axis_tvalid && s_axis_tready;

  assign rd_later = (rd_entry.deadline > dl);
  assign rd_due   = (rd_entry.deadline <= {1'b0, now_r});

  dtq_store #(
    .DEPTH (QUEUE_DEPTH),
    .AW    (AW)
  ) u_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (mem_waddr),
    .wdata (mem_wdata),
    .re    (mem_re),
    .raddr (mem_raddr),
    .rdata (rd_entry)
  );

  dtq_div u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (rd_entry.deadline - {1'b0, now_r}),
    .done     (div_done),
    .quotient (div_q)
  );

  // Next state
  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          if (in_op == OP_SERVICE) begin
            state_next = ST_SRV_READ;
          end else if (!in_neg && !q_full) begin
            state_next = ST_INS_STEP;
          end
        end
      end
      ST_INS_STEP: begin
        state_next = (pos == '0) ? ST_INS_DONE : ST_INS_CMP;
      end
      ST_INS_CMP: begin
        if (rd_later) begin
          state_next = (pos >= CW'(2)) ? ST_INS_CMP : ST_INS_STEP;
        end else begin
          state_next = ST_INS_DONE;
        end
      end
      ST_INS_DONE: begin
        if (out_free) state_next = ST_IDLE;
      end
      ST_SRV_READ: begin
        if (count != '0) begin
          state_next = ST_SRV_CMP;
        end else if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      ST_SRV_CMP: begin
        if (!rd_due) begin
          state_next = ST_SRV_DIV;
        end else if (out_free) begin
          state_next = ST_SRV_READ;
        end
      end
      ST_SRV_DIV: begin
        if (div_done && out_free) state_next = ST_IDLE;
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // Outputs: memory accesses, divider start, result loads, pointer updates
  always_comb begin
    mem_we     = 1'b0;
    mem_waddr  = to_phys(head, pos);
    mem_wdata  = '{deadline: dl, task_id: task_r};
    mem_re     = 1'b0;
    mem_raddr  = to_phys(head, pos - CW'(1));
    div_start  = 1'b0;
    out_load   = 1'b0;
    out_kind   = KIND_ACCEPTED;
    out_task   = '0;
    out_wait   = '0;
    out_last   = 1'b1;
    head_next  = head;
    count_next = count;
    pos_next   = pos;
    load_item  = 1'b0;
    unique case (state)
      ST_IDLE: begin
        if (accept) begin
          load_item = 1'b1;
          pos_next  = count;
          if (in_op == OP_SCHEDULE) begin
            if (in_neg) begin
              out_load = 1'b1;
              out_kind = KIND_NEGATIVE;
            end else if (q_full) begin
              out_load = 1'b1;
              out_kind = KIND_FULL;
            end
          end
        end
      end
      ST_INS_STEP: begin
        if (pos == '0) begin
          mem_we = 1'b1;
        end else begin
          mem_re = 1'b1;
        end
      end
      ST_INS_CMP: begin
        mem_we = 1'b1;
        if (rd_later) begin
          // shift the later entry up one place and look at the next one down
          mem_wdata = rd_entry;
          pos_next  = pos - CW'(1);
          mem_raddr = to_phys(head, pos - CW'(2));
          mem_re    = (pos >= CW'(2));
        end
      end
      ST_INS_DONE: begin
        if (out_free) begin
          out_load   = 1'b1;
          out_kind   = KIND_ACCEPTED;
          count_next = count + CW'(1);
        end
      end
      ST_SRV_READ: begin
        mem_raddr = head;
        if (count != '0) begin
          mem_re = 1'b1;
        end else if (out_free) begin
          out_load = 1'b1;
          out_kind = KIND_EMPTY;
        end
      end
      ST_SRV_CMP: begin
        if (!rd_due) begin
          div_start = 1'b1;
        end else if (out_free) begin
          out_load   = 1'b1;
          out_kind   = KIND_DUE;
          out_task   = rd_entry.task_id;
          out_last   = 1'b0;
          head_next  = (head == AW'(QUEUE_DEPTH - 1)) ? '0 : head + AW'(1);
          count_next = count - CW'(1);
        end
      end
      ST_SRV_DIV: begin
        if (div_done && out_free) begin
          out_load = 1'b1;
          out_kind = KIND_WAIT;
          out_wait = div_q;
        end
      end
      default: begin
      end
    endcase
  end

  // Control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      head      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      head  <= head_next;
      count <= count_next;
      if (out_load) begin
        out_valid <= 1'b1;
      end else if (m_axis_tready) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Item and result payload registers
  always_ff @(posedge clk) begin
    pos <= pos_next;
    if (load_item) begin
      dl     <= {1'b0, in_now} + DEADLINE_W'(in_delay[DELAY_W-2:0]);
      task_r <= in_task;
      now_r  <= in_now;
    end
    if (out_load) begin
      kind_r  <= out_kind;
      woken_r <= out_task;
      wait_r  <= out_wait;
      last_r  <= out_last;
    end
  end

  assign m_axis_tvalid = out_valid;
  assign m_axis_tdata  = {1'b0, wait_r, woken_r};
  assign m_axis_tuser  = kind_r;
  assign m_axis_tlast  = last_r;

  // Fill count moves by at most one per cycle
  a_count_step: assert property (@(posedge clk) disable iff (rst)
    (count != $past(count)) |->
      ((count == $past(count) + CW'(1)) || ($past(count) == count + CW'(1))))
    else $error("queue fill count jumped");

  // A due task is never the final result of a service item
  a_due_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && (m_axis_tuser == KIND_DUE)) |-> !m_axis_tlast)
    else $error("due result marked last");

  // A valid schedule at full capacity is dropped at once
  a_full_drop: assert property (@(posedge clk) disable iff (rst)
    (accept && (in_op == OP_SCHEDULE) && !in_neg && q_full) |=>
      (m_axis_tvalid && (m_axis_tuser == KIND_FULL) && $stable(count)))
    else $error("full queue did not drop the item");

endmodule

// ----- hdl/dtq_store.sv -----
// Entry memory of the timer queue: one write port, one read port, registered read.
// Depends on dtq_pkg for entry_t.
module dtq_store #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic            clk,
  input  logic            we,
  input  logic [AW-1:0]   waddr,
  input  dtq_pkg::entry_t wdata,
  input  logic            re,
  input  logic [AW-1:0]   raddr,
  output dtq_pkg::entry_t rdata
);
  import dtq_pkg::*;

  entry_t mem [DEPTH];

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Read port, data held until the next read
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hdl/dtq_div.sv -----
// Pipelined divide of a 49-bit microsecond span by 1000 through a reciprocal
// multiply, saturated to the wait width. Depends on dtq_pkg for widths and constants.
module dtq_div (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             start,
  input  logic [dtq_pkg::DEADLINE_W-1:0]   dividend,
  output logic                             done,
  output logic [dtq_pkg::WAIT_W-1:0]       quotient
);
  import dtq_pkg::*;

  localparam int SPAN_LSB = 3;                    // divide by 8 first, then by 125
  localparam int YL_W     = 19;
  localparam int YH_W     = 19;
  localparam int ML_W     = 20;
  localparam int MH_W     = RECIP_W - ML_W;
  localparam int PP_W     = 39;
  localparam int SUM_W    = YL_W + YH_W + RECIP_W;

  logic [DEADLINE_W-1:0] span;
  logic [YL_W-1:0]       y_lo;
  logic [YH_W-1:0]       y_hi;
  logic [ML_W-1:0]       m_lo;
  logic [MH_W-1:0]       m_hi;
  logic [PP_W-1:0]       pp_hh, pp_hl, pp_lh, pp_ll;
  logic [SUM_W-1:0]      sum_a, sum_b, prod;
  logic                  sat1, sat2;
  logic [2:0]            stage;
  logic [WAIT_W-1:0]     q;

  // Operand slices; a span below SAT_SPAN fits in 41 bits
  assign y_lo = span[SPAN_LSB +: YL_W];
  assign y_hi = span[SPAN_LSB + YL_W +: YH_W];
  assign m_lo = RECIP_125[ML_W-1:0];
  assign m_hi = RECIP_125[RECIP_W-1:ML_W];
  assign prod = sum_a + sum_b;

  // Stage valid bits and sticky done, cleared by the next start
  always_ff @(posedge clk) begin
    if (rst) begin
      stage <= '0;
      done  <= 1'b0;
    end else begin
      stage <= {stage[1:0], start};
      if (start) begin
        done <= 1'b0;
      end else if (stage[2]) begin
        done <= 1'b1;
      end
    end
  end

  // Capture, partial products, partial sums, quotient
  always_ff @(posedge clk) begin
    if (start) begin
      span <= dividend;
    end
    sat1  <= (span >= SAT_SPAN);
    pp_hh <= PP_W'(y_hi) * PP_W'(m_hi);
    pp_hl <= PP_W'(y_hi) * PP_W'(m_lo);
    pp_lh <= PP_W'(y_lo) * PP_W'(m_hi);
    pp_ll <= PP_W'(y_lo) * PP_W'(m_lo);
    sat2  <= sat1;
    sum_a <= (SUM_W'(pp_hh) << (YL_W + ML_W)) + SUM_W'(pp_ll);
    sum_b <= (SUM_W'(pp_hl) << YL_W) + (SUM_W'(pp_lh) << ML_W);
    q     <= sat2 ? WAIT_MAX : prod[RECIP_SHIFT +: WAIT_W];
  end

  assign quotient = q;

endmodule

// ----- dv/testbench.sv -----
// Self-checking testbench for deadline_timer_queue: directed and random items
// with an in-bench timer queue predictor. Depends on dtq_pkg and the RTL.
`timescale 1ns / 100ps

module testbench;
  import dtq_pkg::*;

  localparam int SLOTS = 16;
  localparam int QUIET_LIMIT = 4000;
  localparam logic [NOW_W-1:0] T0 = 48'h0000_8000_0000;
  localparam logic [NOW_W-1:0] NOW_MAX = '1;
  localparam logic [DELAY_W-1:0] DELAY_MAX = 41'h0FF_FFFF_FFFF;
  localparam logic [DELAY_W-1:0] DELAY_MIN = 41'h100_0000_0000;

  typedef struct packed {
    logic [KIND_W-1:0] kind;
    logic [TASK_W-1:0] woken;
    logic [WAIT_W-1:0] wait_ms;
    logic              last;
  } wake_result_t;

  // Sorted sleeper store plus the results still owed by the block
  class wake_scoreboard;
    logic [DEADLINE_W-1:0] deadline_mem[SLOTS];
    logic [TASK_W-1:0]     sleeper_mem[SLOTS];
    int                    sleeper_count;
    wake_result_t          owed_q[$];
    int                    errors;

    function new();
      sleeper_count = 0;
      errors = 0;
    endfunction

    function int pending();
      return owed_q.size();
    endfunction

    function void owe(logic [KIND_W-1:0] kind, logic [TASK_W-1:0] woken,
                      logic [WAIT_W-1:0] wait_ms, logic last);
      wake_result_t r;
      r.kind = kind;
      r.woken = woken;
      r.wait_ms = wait_ms;
      r.last = last;
      owed_q.push_back(r);
    endfunction

    // Predict the results of one accepted input item
    function void note_item(logic op, logic [TASK_W-1:0] id,
                            logic [DELAY_W-1:0] delay, logic [NOW_W-1:0] now);
      logic [DEADLINE_W-1:0] dl;
      logic [DEADLINE_W-1:0] diff;
      logic [DEADLINE_W-1:0] ms;
      int pos;
      int due;
      int i;
      if (op == OP_SCHEDULE) begin
        if (delay[DELAY_W-1]) begin
          owe(KIND_NEGATIVE, '0, '0, 1'b1);
        end else if (sleeper_count >= SLOTS) begin
          owe(KIND_FULL, '0, '0, 1'b1);
        end else begin
          dl = {1'b0, now} + {8'd0, delay};
          pos = sleeper_count;
          // later deadlines move up; equal ones keep arrival order
          while (pos > 0 && deadline_mem[pos-1] > dl) pos--;
          for (i = sleeper_count; i > pos; i--) begin
            deadline_mem[i] = deadline_mem[i-1];
            sleeper_mem[i] = sleeper_mem[i-1];
          end
          deadline_mem[pos] = dl;
          sleeper_mem[pos] = id;
          sleeper_count++;
          owe(KIND_ACCEPTED, '0, '0, 1'b1);
        end
      end else begin
        due = 0;
        // deadline equal to now counts as passed
        while (due < sleeper_count && deadline_mem[due] <= {1'b0, now}) begin
          owe(KIND_DUE, sleeper_mem[due], '0, 1'b0);
          due++;
        end
        for (i = due; i < sleeper_count; i++) begin
          deadline_mem[i-due] = deadline_mem[i];
          sleeper_mem[i-due] = sleeper_mem[i];
        end
        sleeper_count -= due;
        if (sleeper_count == 0) begin
          owe(KIND_EMPTY, '0, '0, 1'b1);
        end else begin
          diff = deadline_mem[0] - {1'b0, now};
          ms = diff / DEADLINE_W'(US_PER_MS);
          if (ms > DEADLINE_W'(WAIT_MAX)) ms = DEADLINE_W'(WAIT_MAX);
          owe(KIND_WAIT, '0, ms[WAIT_W-1:0], 1'b1);
        end
      end
    endfunction

    // Compare one output item with the oldest owed result
    function void check_item(logic [KIND_W-1:0] kind, logic [TASK_W-1:0] woken,
                             logic [WAIT_W-1:0] wait_ms, logic last);
      wake_result_t exp;
      if (owed_q.size() == 0) begin
        $display("%0t: unexpected result, expected none, actual kind %0d",
                 $time, kind);
        errors++;
        return;
      end
      exp = owed_q.pop_front();
      if (kind !== exp.kind) begin
        $display("%0t: result_kind expected %0d actual %0d", $time, exp.kind, kind);
        errors++;
      end
      if (woken !== exp.woken) begin
        $display("%0t: woken_task expected %0d actual %0d", $time, exp.woken, woken);
        errors++;
      end
      if (wait_ms !== exp.wait_ms) begin
        $display("%0t: wait_ms expected %0d actual %0d", $time, exp.wait_ms, wait_ms);
        errors++;
      end
      if (last !== exp.last) begin
        $display("%0t: last expected %0d actual %0d", $time, exp.last, last);
        errors++;
      end
    endfunction
  endclass

  logic         clk = 1'b0;
  logic         rst = 1'b1;
  logic         s_axis_tvalid = 1'b0;
  logic         s_axis_tready;
  logic [111:0] s_axis_tdata = '0;
  logic         s_axis_tuser = 1'b0;
  logic         m_axis_tvalid;
  logic         m_axis_tready = 1'b0;
  logic [47:0]  m_axis_tdata;
  logic [2:0]   m_axis_tuser;
  logic         m_axis_tlast;
  logic         steady = 1'b0;
  int           quiet = 0;
  wake_scoreboard sb;

  deadline_timer_queue #(.QUEUE_DEPTH(SLOTS)) i_dut (
    .clk           (clk),
    .rst           (rst),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser),
    .m_axis_tlast  (m_axis_tlast)
  );

  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // Receiver stalls about 8 percent of the time, never during the steady stretch
  always @(posedge clk) begin
    m_axis_tready <= steady || ($urandom_range(0, 99) >= 8);
  end

  // Result monitor
  always @(posedge clk) begin
    if (!rst && m_axis_tvalid && m_axis_tready)
      sb.check_item(m_axis_tuser, m_axis_tdata[15:0], m_axis_tdata[46:16], m_axis_tlast);
  end

  // Watchdog on cycles with no item moving on either side
  always @(posedge clk) begin
    if (rst || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
      quiet <= 0;
    end else begin
      quiet <= quiet + 1;
      if (quiet == QUIET_LIMIT) begin
        $display("%0t: no progress for %0d cycles", $time, QUIET_LIMIT);
        $display("[FAIL] regression broken");
        $finish;
      end
    end
  end

  // Offer one input item, with random idle cycles ahead of it
  task automatic send_item(input logic op, input logic [TASK_W-1:0] id,
                           input logic [DELAY_W-1:0] delay,
                           input logic [NOW_W-1:0] now);
    while (!steady && $urandom_range(0, 99) < 8) begin
      s_axis_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tuser <= op;
    s_axis_tdata <= {7'd0, now, delay, id};
    do @(posedge clk); while (!s_axis_tready);
    sb.note_item(op, id, delay, now);
  endtask

  task automatic schedule_task(input logic [TASK_W-1:0] id,
                               input logic [DELAY_W-1:0] delay,
                               input logic [NOW_W-1:0] now);
    send_item(OP_SCHEDULE, id, delay, now);
  endtask

  // task_id and delay are don't-care for a service item; keep them moving
  task automatic service_at(input logic [NOW_W-1:0] now);
    logic [63:0] junk;
    junk = {$urandom, $urandom};
    send_item(OP_SERVICE, junk[15:0], junk[56:16], now);
  endtask

  // Hold the sender until every owed result has come back
  task automatic drain_results();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk); while (sb.pending() != 0);
  endtask

  initial begin
    int n;
    int pick;
    int i;
    logic [63:0] r64;
    logic [NOW_W-1:0] now_t;
    sb = new();
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Directed: empty queue, negative delay, fill with ties, full, drain all
    service_at('0);
    schedule_task(16'hFFFF, DELAY_MIN, '0);
    for (i = 0; i < SLOTS; i++)
      schedule_task(TASK_W'(16'h0100 + i), DELAY_W'((i % 4) * 500), T0);
    schedule_task(16'hFFFF, DELAY_MAX, NOW_MAX);
    schedule_task(16'h0000, '1, T0);
    service_at(T0 + 1500);
    // Deadlines in the upper half of the clock: saturated wait, exact wait limit
    schedule_task(16'hA5A5, DELAY_MAX, 48'h8000_0000_0000);
    schedule_task(16'h0000, 41'd1, 48'h7FFF_FFFF_FFFF);
    service_at('0);
    service_at(48'h8000_0000_0000);
    service_at(NOW_MAX);
    drain_results();

    // Random: mostly schedule/service with time moving forward
    r64 = {$urandom, $urandom};
    now_t = {3'b001, r64[44:0]};
    for (n = 0; n < 260; n++) begin
      steady <= (n >= 120 && n < 180);
      if (n % 64 == 63) drain_results();
      pick = $urandom_range(0, 99);
      r64 = {$urandom, $urandom};
      if (pick < 48) begin
        schedule_task(r64[15:0], DELAY_W'($urandom_range(0, 30000)), now_t);
      end else if (pick < 88) begin
        now_t = now_t + NOW_W'($urandom_range(0, 12000));
        service_at(now_t);
      end else if (pick < 92) begin
        schedule_task(r64[15:0], {1'b1, r64[55:16]}, now_t);
      end else if (pick < 94) begin
        schedule_task(r64[15:0], {1'b0, r64[55:16]}, now_t);
      end else if (pick < 96) begin
        // big jump forward flushes long sleepers
        now_t = now_t + {8'd0, r64[39:0]};
        service_at(now_t);
      end else begin
        // clock read going backwards
        service_at(now_t - NOW_W'($urandom_range(0, 40000)));
      end
    end

    drain_results();
    repeat (64) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

endmodule
